// ===== sv/vsa_pkg.sv =====
// ----------------------------------------------------------------------------
// vsa_pkg: shared types and codes for the voice slot allocator
// function codes, slot status codes, table entry layout and candidate
// unit control and status groups
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vsa_pkg;

  localparam int SLOT_W = 6;
  localparam int AGE_W  = 32;

  // function codes
  localparam logic [1:0] FN_WRITE   = 2'd0;
  localparam logic [1:0] FN_ALLOC   = 2'd1;
  localparam logic [1:0] FN_RELEASE = 2'd2;

  // slot status codes
  localparam logic [1:0] ST_FREE     = 2'd0;
  localparam logic [1:0] ST_STEAL    = 2'd1;
  localparam logic [1:0] ST_EFFECT   = 2'd2;
  localparam logic [1:0] ST_RESERVED = 2'd3;

  typedef struct packed {
    logic             lock;
    logic [1:0]       status;
    logic [AGE_W-1:0] age;
  } entry_t;

  typedef struct packed {
    logic clear;  // drop the best candidate
    logic eval;   // an entry is presented this cycle
    logic steal;  // look for stealable slots instead of free ones
  } cand_ctrl_t;

  typedef struct packed {
    logic hit;    // presented entry matches the wanted status and is unlocked
    logic have;   // a steal candidate is held
  } cand_stat_t;

endpackage

// ===== sv/vsa_ram.sv =====
// ----------------------------------------------------------------------------
// vsa_ram: generic single-port-write, single-port-read ram
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vsa_ram #(
  parameter int WIDTH = 35,
  parameter int DEPTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/vsa_cand.sv =====
// ----------------------------------------------------------------------------
// vsa_cand: shared candidate compare unit
// matches one entry per cycle and keeps the oldest-first steal candidate
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vsa_cand #(
  parameter int SLOT_AW = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vsa_pkg::cand_ctrl_t  ctrl_i,
  input  vsa_pkg::entry_t      entry_i,
  input  logic [SLOT_AW-1:0]   slot_i,
  output vsa_pkg::cand_stat_t  stat_o,
  output logic [SLOT_AW-1:0]   best_slot_o
);

  logic                      have_q, have_d;
  logic [SLOT_AW-1:0]        best_slot_q, best_slot_d;
  logic [vsa_pkg::AGE_W-1:0] best_age_q, best_age_d;
  logic [1:0]                want;
  logic                      hit;

  assign want = ctrl_i.steal ? vsa_pkg::ST_STEAL : vsa_pkg::ST_FREE;
  assign hit  = ctrl_i.eval && !entry_i.lock && (entry_i.status == want);

  always_comb begin
    have_d      = have_q;
    best_slot_d = best_slot_q;
    best_age_d  = best_age_q;
    if (ctrl_i.clear) begin
      have_d = 1'b0;
    end else if (ctrl_i.steal && hit && (!have_q || (entry_i.age < best_age_q))) begin
      // strictly smaller age wins, so ties keep the slot scanned earlier
      have_d      = 1'b1;
      best_slot_d = slot_i;
      best_age_d  = entry_i.age;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else begin
      have_q <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_slot_q <= best_slot_d;
    best_age_q  <= best_age_d;
  end

  assign stat_o.hit   = hit;
  assign stat_o.have  = have_q;
  assign best_slot_o  = best_slot_q;

endmodule

// ===== sv/voice_slot_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// voice_slot_allocator_unit: round-robin voice slot allocator with stealing
// write words pass through dispatch to done; release words add a table read and a
// write-back of a reserved slot as free; an allocate word scans from the scan pointer
// for the first unlocked free slot and falls back to a steal scan over all slots
// when there is none, with one table ram read issued per slot
// one word at a time: the next word is taken the cycle after a result is
// registered; reset empties the table through per-slot valid bits at once
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module voice_slot_allocator_unit #(
  parameter int NUM_SLOTS = 48
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input words
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  func_i,
  input  logic [vsa_pkg::SLOT_W-1:0]  slot_index_i,
  input  logic                        locked_i,
  input  logic [1:0]                  status_i,
  input  logic [vsa_pkg::AGE_W-1:0]   age_i,
  // result words
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [vsa_pkg::SLOT_W-1:0]  chosen_slot_o,
  output logic                        found_o
);

  localparam int AW = $clog2(NUM_SLOTS);       // table address width
  localparam int CW = $clog2(NUM_SLOTS + 1);   // scan counters hold NUM_SLOTS
  localparam int EW = $bits(vsa_pkg::entry_t);
  localparam logic [AW-1:0] LAST_SLOT = AW'(NUM_SLOTS - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(NUM_SLOTS);
  localparam logic [CW-1:0] LAST_CNT  = CW'(NUM_SLOTS - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_REL      = 3'd2;
  localparam logic [2:0] S_FREE     = 3'd3;
  localparam logic [2:0] S_STEAL    = 3'd4;
  localparam logic [2:0] S_STEND    = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  logic [2:0]                       state_q, state_d;
  // captured input word
  logic [1:0]                       func_q, func_d;
  logic [vsa_pkg::SLOT_W-1:0]       idx_q, idx_d;
  logic                             lock_q, lock_d;
  logic [1:0]                       status_q, status_d;
  logic [vsa_pkg::AGE_W-1:0]        age_q, age_d;
  // scan state
  logic [AW-1:0]                    ptr_q, ptr_d;
  logic [AW-1:0]                    addr_q, addr_d;
  logic [CW-1:0]                    iss_cnt_q, iss_cnt_d;
  logic [CW-1:0]                    eval_cnt_q, eval_cnt_d;
  logic                             eval_v_q, eval_v_d;
  logic [AW-1:0]                    eval_slot_q, eval_slot_d;
  logic                             rd_valid_q, rd_valid_d;
  logic [NUM_SLOTS-1:0]             valid_q, valid_d;
  // result
  logic                             res_found_q, res_found_d;
  logic [AW-1:0]                    res_slot_q, res_slot_d;
  logic                             out_valid_q, out_valid_d;
  logic                             out_found_q, out_found_d;
  logic [vsa_pkg::SLOT_W-1:0]       out_slot_q, out_slot_d;

  // table ram
  logic                             ram_we;
  logic [AW-1:0]                    ram_waddr;
  vsa_pkg::entry_t                  ram_wdata;
  logic                             ram_re;
  logic [AW-1:0]                    ram_raddr;
  logic [EW-1:0]                    ram_rdata;
  vsa_pkg::entry_t                  rd_entry;

  // candidate unit
  vsa_pkg::cand_ctrl_t              cand_ctrl;
  vsa_pkg::cand_stat_t              cand_stat;
  logic [AW-1:0]                    cand_best;

  logic                             idx_in_range;
  logic [AW-1:0]                    idx_addr;
  logic [AW-1:0]                    addr_next;

  vsa_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  vsa_cand #(
    .SLOT_AW (AW)
  ) u_cand (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (cand_ctrl),
    .entry_i     (rd_entry),
    .slot_i      (eval_slot_q),
    .stat_o      (cand_stat),
    .best_slot_o (cand_best)
  );

  // a slot never written since reset reads as the all-zero entry
  assign rd_entry = rd_valid_q ? vsa_pkg::entry_t'(ram_rdata) : '0;

  assign idx_in_range = (7'(idx_q) < 7'(NUM_SLOTS));
  assign idx_addr     = idx_q[AW-1:0];
  // scan address walks forward and wraps at the last slot
  assign addr_next    = (addr_q == LAST_SLOT) ? '0 : addr_q + AW'(1);

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign chosen_slot_o = out_slot_q;
  assign found_o       = out_found_q;

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    idx_d       = idx_q;
    lock_d      = lock_q;
    status_d    = status_q;
    age_d       = age_q;
    ptr_d       = ptr_q;
    addr_d      = addr_q;
    iss_cnt_d   = iss_cnt_q;
    eval_cnt_d  = eval_cnt_q;
    eval_v_d    = eval_v_q;
    eval_slot_d = eval_slot_q;
    rd_valid_d  = rd_valid_q;
    valid_d     = valid_q;
    res_found_d = res_found_q;
    res_slot_d  = res_slot_q;
    out_valid_d = out_valid_q;
    out_found_d = out_found_q;
    out_slot_d  = out_slot_q;

    ram_we    = 1'b0;
    ram_waddr = idx_addr;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = addr_q;
    cand_ctrl = '0;

    // result word taken downstream
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          func_d   = func_i;
          idx_d    = slot_index_i;
          lock_d   = locked_i;
          status_d = status_i;
          age_d    = age_i;
          state_d  = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        res_found_d = 1'b0;
        res_slot_d  = '0;
        state_d     = S_DONE;
        case (func_q)
          vsa_pkg::FN_WRITE: begin
            if (idx_in_range) begin
              ram_we           = 1'b1;
              ram_wdata.lock   = lock_q;
              ram_wdata.status = status_q;
              ram_wdata.age    = age_q;
              valid_d[idx_addr] = 1'b1;
            end
          end
          vsa_pkg::FN_RELEASE: begin
            if (idx_in_range) begin
              ram_re     = 1'b1;
              ram_raddr  = idx_addr;
              rd_valid_d = valid_q[idx_addr];
              state_d    = S_REL;
            end
          end
          vsa_pkg::FN_ALLOC: begin
            addr_d     = ptr_q;
            iss_cnt_d  = '0;
            eval_cnt_d = '0;
            eval_v_d   = 1'b0;
            state_d    = S_FREE;
          end
          default: begin
            // unused code: empty result
          end
        endcase
      end

      S_REL: begin
        // reserved turns free, lock and age stay
        if (rd_entry.status == vsa_pkg::ST_RESERVED) begin
          ram_we           = 1'b1;
          ram_wdata        = rd_entry;
          ram_wdata.status = vsa_pkg::ST_FREE;
        end
        state_d = S_DONE;
      end

      S_FREE, S_STEAL: begin
        // issue one read per cycle, judge it the cycle after
        if (iss_cnt_q != FULL_CNT) begin
          ram_re      = 1'b1;
          ram_raddr   = addr_q;
          rd_valid_d  = valid_q[addr_q];
          eval_slot_d = addr_q;
          eval_v_d    = 1'b1;
          iss_cnt_d   = iss_cnt_q + CW'(1);
          addr_d      = addr_next;
        end else begin
          eval_v_d = 1'b0;
        end
        cand_ctrl.eval  = eval_v_q;
        cand_ctrl.steal = (state_q == S_STEAL);
        if (eval_v_q) begin
          eval_cnt_d = eval_cnt_q + CW'(1);
        end

        if (state_q == S_FREE) begin
          if (eval_v_q && cand_stat.hit) begin
            // first free slot: pointer parks on it
            res_found_d = 1'b1;
            res_slot_d  = eval_slot_q;
            ptr_d       = eval_slot_q;
            state_d     = S_DONE;
          end else if (eval_v_q && (eval_cnt_q == LAST_CNT)) begin
            // no free slot: rescan from the same pointer for a steal
            addr_d          = ptr_q;
            iss_cnt_d       = '0;
            eval_cnt_d      = '0;
            eval_v_d        = 1'b0;
            cand_ctrl.clear = 1'b1;
            state_d         = S_STEAL;
          end
        end else if (eval_v_q && (eval_cnt_q == LAST_CNT)) begin
          state_d = S_STEND;
        end
      end

      S_STEND: begin
        res_found_d = cand_stat.have;
        res_slot_d  = cand_stat.have ? cand_best : '0;
        state_d     = S_DONE;
      end

      S_DONE: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_found_d = res_found_q;
          out_slot_d  = vsa_pkg::SLOT_W'(res_slot_q);
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= '0;
      valid_q     <= '0;
      iss_cnt_q   <= '0;
      eval_cnt_q  <= '0;
      eval_v_q    <= 1'b0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      valid_q     <= valid_d;
      iss_cnt_q   <= iss_cnt_d;
      eval_cnt_q  <= eval_cnt_d;
      eval_v_q    <= eval_v_d;
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    idx_q       <= idx_d;
    lock_q      <= lock_d;
    status_q    <= status_d;
    age_q       <= age_d;
    addr_q      <= addr_d;
    eval_slot_q <= eval_slot_d;
    res_found_q <= res_found_d;
    res_slot_q  <= res_slot_d;
    out_found_q <= out_found_d;
    out_slot_q  <= out_slot_d;
  end

endmodule

// ===== sim/tb_voice_slot_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_voice_slot_allocator_unit: self-checking bench for the voice slot allocator
// a short directed run covers the edge cases of the table and the scan;
// randomized table fills with allocate/release traffic follow; every word is
// predicted on acceptance and checked against the result words in order,
// with random gaps on the input side and random stalls on the result side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_voice_slot_allocator_unit;
  import vsa_pkg::*;

  localparam int NUM_SLOTS    = 48;
  localparam int WORD_TARGET  = 850;
  localparam int CYCLE_LIMIT  = 1_000_000;
  // drain margin covers the worst allocate: a full free scan and a full steal scan
  localparam int DRAIN_CYCLES = 2 * NUM_SLOTS + 20;
  localparam logic [1:0] FN_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]        func;
    logic [SLOT_W-1:0] slot_index;
    logic              locked;
    logic [1:0]        status;
    logic [AGE_W-1:0]  age;
  } word_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              found;
  } grant_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [SLOT_W-1:0] chosen_slot;
  logic              found;
  word_t             drv_word  = '0;

  word_t  pending_words[$];
  grant_t expected_grants[$];

  // predicted allocator state
  logic             voice_lock   [NUM_SLOTS];
  logic [1:0]       voice_status [NUM_SLOTS];
  logic [AGE_W-1:0] voice_age    [NUM_SLOTS];
  int               scan_ptr;

  int words_sent  = 0;
  int words_taken = 0;
  int errors      = 0;
  int idle_left   = 0;
  int stall_left  = 0;
  int cycles      = 0;

  voice_slot_allocator_unit #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .func_i        (drv_word.func),
    .slot_index_i  (drv_word.slot_index),
    .locked_i      (drv_word.locked),
    .status_i      (drv_word.status),
    .age_i         (drv_word.age),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .chosen_slot_o (chosen_slot),
    .found_o       (found)
  );

  always #6 clk_i = ~clk_i;

  // applies one word to the predicted table and returns its grant
  function automatic grant_t predict_grant(input word_t w);
    grant_t           g;
    int               s;
    int               k;
    logic             have;
    logic [AGE_W-1:0] best_age;
    g        = '0;
    have     = 1'b0;
    best_age = '0;
    case (w.func)
      FN_WRITE: begin
        if (w.slot_index < NUM_SLOTS) begin
          voice_lock[w.slot_index]   = w.locked;
          voice_status[w.slot_index] = w.status;
          voice_age[w.slot_index]    = w.age;
        end
      end
      FN_RELEASE: begin
        if (w.slot_index < NUM_SLOTS && voice_status[w.slot_index] == ST_RESERVED)
          voice_status[w.slot_index] = ST_FREE;
      end
      FN_ALLOC: begin
        // first unlocked free slot from the pointer, wrapping
        for (k = 0; k < NUM_SLOTS; k++) begin
          s = (scan_ptr + k) % NUM_SLOTS;
          if (!g.found && !voice_lock[s] && voice_status[s] == ST_FREE) begin
            g.found = 1'b1;
            g.slot  = SLOT_W'(s);
          end
        end
        if (g.found) begin
          scan_ptr = int'(g.slot);
        end else begin
          // steal: strictly smallest age wins, so ties keep the earliest in scan order
          for (k = 0; k < NUM_SLOTS; k++) begin
            s = (scan_ptr + k) % NUM_SLOTS;
            if (!voice_lock[s] && voice_status[s] == ST_STEAL &&
                (!have || voice_age[s] < best_age)) begin
              have     = 1'b1;
              best_age = voice_age[s];
              g.slot   = SLOT_W'(s);
            end
          end
          g.found = have;
        end
      end
      default: ;
    endcase
    return g;
  endfunction

  // mostly short gaps, a few long ones, none at all in quiet stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if ((words_sent / 96) % 4 == 2) return 0;
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // small ages make ties likely, the extremes show up now and then
  function automatic logic [AGE_W-1:0] rand_age();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return AGE_W'($urandom_range(0, 7));
    if (r == 4) return '0;
    if (r == 5) return '1;
    return $urandom;
  endfunction

  // status mix for a table fill: steal heavy, no candidates, or mixed
  function automatic logic [1:0] fill_status(input int kind);
    int r;
    r = $urandom_range(0, 99);
    case (kind)
      0:       return (r < 3) ? ST_FREE : (r < 75) ? ST_STEAL :
                      (r < 88) ? ST_EFFECT : ST_RESERVED;
      1:       return (r < 50) ? ST_EFFECT : ST_RESERVED;
      default: return (r < 10) ? ST_FREE : (r < 40) ? ST_STEAL :
                      (r < 70) ? ST_EFFECT : ST_RESERVED;
    endcase
  endfunction

  task automatic push_word(input logic [1:0] f, input int idx, input logic lk,
                           input logic [1:0] st, input logic [AGE_W-1:0] ag);
    word_t w;
    w.func       = f;
    w.slot_index = SLOT_W'(idx);
    w.locked     = lk;
    w.status     = st;
    w.age        = ag;
    pending_words.push_back(w);
  endtask

  // input side: a word stays up until taken, then an optional gap
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid && words_taken != words_sent)) begin
      if (idle_left > 0) begin
        idle_left--;
        in_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        drv_word = pending_words.pop_front();
        words_sent++;
        idle_left = pick_gap();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // word accepted: predict its grant
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && in_ready) begin
      expected_grants.push_back(predict_grant(drv_word));
      words_taken++;
    end
  end

  // result side stalls
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left == 0 && $urandom_range(0, 7) == 0) stall_left = pick_gap();
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // result check against the oldest prediction
  always @(posedge clk_i) begin
    grant_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_grants.size() == 0) begin
        $display("%0t: unexpected result word: slot %0d found %0b", $time, chosen_slot,
                 found);
        errors++;
      end else begin
        want = expected_grants.pop_front();
        if (chosen_slot !== want.slot) begin
          $display("%0t: chosen_slot expected %0d got %0d", $time, want.slot, chosen_slot);
          errors++;
        end
        if (found !== want.found) begin
          $display("%0t: found expected %0b got %0b", $time, want.found, found);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("voice_slot_allocator_unit: mismatch");
      $finish;
    end
  end

  initial begin
    int i;
    int n;
    int kind;
    int base;
    int r;
    for (i = 0; i < NUM_SLOTS; i++) begin
      voice_lock[i]   = 1'b0;
      voice_status[i] = ST_FREE;
      voice_age[i]    = '0;
    end
    scan_ptr = 0;

    // directed: reset table, lock skip, ignored items, release paths
    push_word(FN_ALLOC, 0, 1'b0, ST_FREE, '0);             // empty table gives slot 0
    push_word(FN_WRITE, 0, 1'b1, ST_FREE, '0);             // locked free slot
    push_word(FN_ALLOC, 63, 1'b1, ST_RESERVED, '1);        // skips the lock, moves on
    push_word(FN_WRITE, 63, 1'b1, ST_RESERVED, '1);        // out of range write
    push_word(FN_RELEASE, 50, 1'b0, ST_FREE, '0);          // out of range release
    push_word(FN_UNUSED, 63, 1'b1, ST_RESERVED, '1);       // unused code
    push_word(FN_WRITE, 47, 1'b0, ST_RESERVED, '1);
    push_word(FN_RELEASE, 47, 1'b1, ST_RESERVED, '1);      // reserved back to free
    push_word(FN_RELEASE, 1, 1'b0, ST_FREE, '0);           // already free, no change
    push_word(FN_WRITE, 1, 1'b0, ST_EFFECT, '0);
    push_word(FN_ALLOC, 0, 1'b0, ST_FREE, '0);
    push_word(FN_WRITE, 2, 1'b0, ST_STEAL, '1);
    push_word(FN_ALLOC, 0, 1'b0, ST_FREE, '0);
    push_word(FN_RELEASE, 2, 1'b0, ST_FREE, '0);           // stealable, not released
    push_word(FN_ALLOC, 0, 1'b0, ST_FREE, '0);

    // random: table fills so that steals and empty scans happen, then mixed traffic
    n = pending_words.size() + WORD_TARGET;
    while (pending_words.size() < n) begin
      if ($urandom_range(0, 2) != 0) begin
        kind = $urandom_range(0, 2);
        base = $urandom_range(0, NUM_SLOTS - 1);
        for (i = 0; i < NUM_SLOTS; i++)
          push_word(FN_WRITE, (base + i) % NUM_SLOTS, ($urandom_range(0, 4) == 0),
                    fill_status(kind), rand_age());
      end
      for (i = $urandom_range(10, 40); i > 0; i--) begin
        r = $urandom_range(0, 99);
        if (r < 40)
          push_word(FN_ALLOC, $urandom_range(0, 63), 1'($urandom_range(0, 1)),
                    2'($urandom_range(0, 3)), $urandom);
        else if (r < 65)
          push_word(FN_WRITE, $urandom_range(0, NUM_SLOTS - 1), ($urandom_range(0, 4) == 0),
                    fill_status(2), rand_age());
        else if (r < 85)
          push_word(FN_RELEASE, $urandom_range(0, NUM_SLOTS - 1), 1'($urandom_range(0, 1)),
                    2'($urandom_range(0, 3)), $urandom);
        else if (r < 92)
          push_word($urandom_range(0, 1) ? FN_WRITE : FN_RELEASE,
                    $urandom_range(NUM_SLOTS, 63), 1'($urandom_range(0, 1)),
                    2'($urandom_range(0, 3)), $urandom);
        else
          push_word(FN_UNUSED, $urandom_range(0, 63), 1'($urandom_range(0, 1)),
                    2'($urandom_range(0, 3)), $urandom);
      end
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() != 0 || words_taken != words_sent ||
           expected_grants.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("voice_slot_allocator_unit: match");
    end else begin
      $display("voice_slot_allocator_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/vsa_pkg.sv
sv/vsa_ram.sv
sv/vsa_cand.sv
sv/voice_slot_allocator_unit.sv
sim/tb_voice_slot_allocator_unit.sv
